FILE: rtl/core/b64d_pkg.sv
// Shared types, constants and the character-to-sextet map for the Base64 decoder.
// No dependencies; b64d_step and the top take names from here.
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [5:0] SEXTET_62   = 6'd62;
   localparam logic [5:0] SEXTET_63   = 6'd63;
   localparam logic [5:0] LOWER_BASE  = 6'd26;
   localparam logic [5:0] DIGIT_BASE  = 6'd52;

   // position of the next character within its four-character group
   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2,
      POS_FOURTH = 2'd3
   } group_pos_type;

   typedef struct packed {
      group_pos_type group_pos;
      logic [5:0]    held_sextet;
      logic          pad_skip;
      logic          error_seen;
   } step_state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_word_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       bad_input;
      logic       end_of_string;
   } rsp_word_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // both alphabets: '+' or '-' is 62, '/' or '_' is 63
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] d;
      r = '0;
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
         r.ok = 1'b1;
         r.value = d[5:0];
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61;
         r.ok = 1'b1;
         r.value = d[5:0] + LOWER_BASE;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         r.ok = 1'b1;
         r.value = d[5:0] + DIGIT_BASE;
      end else if (c == 8'h2B || c == 8'h2D) begin
         r.ok = 1'b1;
         r.value = SEXTET_62;
      end else if (c == 8'h2F || c == 8'h5F) begin
         r.ok = 1'b1;
         r.value = SEXTET_63;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64d_req_if.sv
// Character channel: valid/ready handshake carrying one encoded character per word.
// Standalone; no package needed.
`default_nettype none

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/b64d_rsp_if.sv
// Result channel: valid/ready handshake carrying one decode result per word.
// Standalone; no package needed.
`default_nettype none

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] data_byte;
   logic       bad_input;
   logic       end_of_string;

   modport source (output valid, output byte_valid, output data_byte,
                   output bad_input, output end_of_string, input ready);
   modport sink   (input valid, input byte_valid, input data_byte,
                   input bad_input, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/b64d_step.sv
// Per-character decode step: next group state and result word from one character.
// Depends on b64d_pkg.
`default_nettype none

module b64d_step (
   input  var b64d_pkg::step_state_type cur_state,
   input  var b64d_pkg::req_word_type   req_word,
   output b64d_pkg::step_state_type     nxt_state,
   output b64d_pkg::rsp_word_type       rsp_word
);

   b64d_pkg::sextet_type sx;
   b64d_pkg::step_state_type st;
   logic       have;
   logic [7:0] data;
   logic       is_pad;

   assign sx     = b64d_pkg::sextet_of(req_word.char_code);
   assign is_pad = (req_word.char_code == b64d_pkg::PAD_CHAR);

   always_comb begin
      st   = cur_state;
      have = 1'b0;
      data = 8'h00;
      if (cur_state.pad_skip) begin
         // fourth char after '=' in third place: dropped unchecked
         st.pad_skip  = 1'b0;
         st.group_pos = b64d_pkg::POS_FIRST;
      end else begin
         case (cur_state.group_pos)
            b64d_pkg::POS_FIRST: begin
               if (!sx.ok || req_word.last_char) st.error_seen = 1'b1;
               st.held_sextet = sx.value;
               st.group_pos   = b64d_pkg::POS_SECOND;
            end
            b64d_pkg::POS_SECOND: begin
               if (!sx.ok) st.error_seen = 1'b1;
               data = {cur_state.held_sextet, sx.value[5:4]};
               have = sx.ok;
               st.held_sextet = sx.value;
               st.group_pos   = b64d_pkg::POS_THIRD;
            end
            b64d_pkg::POS_THIRD: begin
               if (is_pad) begin
                  st.pad_skip = 1'b1;
               end else begin
                  if (!sx.ok) st.error_seen = 1'b1;
                  data = {cur_state.held_sextet[3:0], sx.value[5:2]};
                  have = sx.ok;
                  st.held_sextet = sx.value;
               end
               st.group_pos = b64d_pkg::POS_FOURTH;
            end
            default: begin
               if (!is_pad) begin
                  if (!sx.ok) st.error_seen = 1'b1;
                  data = {cur_state.held_sextet[1:0], sx.value};
                  have = sx.ok;
               end
               st.group_pos = b64d_pkg::POS_FIRST;
            end
         endcase
      end

      if (st.error_seen) have = 1'b0;

      rsp_word.byte_valid    = have;
      rsp_word.data_byte     = have ? data : 8'h00;
      rsp_word.bad_input     = st.error_seen;
      rsp_word.end_of_string = req_word.last_char;

      // string ends: start afresh
      nxt_state = req_word.last_char ? '0 : st;
   end

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_decoder_top.sv
// Top level of the streaming Base64 decoder: state and result registers, handshake.
// Depends on b64d_pkg, b64d_req_if, b64d_rsp_if and b64d_step.
//
//   channel  modport  word carries                                   accepted when
//   req      sink     char_code[7:0], last_char                      req.valid && req.ready
//   rsp      source   byte_valid, data_byte[7:0], bad_input,         rsp.valid && rsp.ready
//                     end_of_string
//
// One result word per character, one character per cycle sustained while rsp.ready is high.
// A result appears in the cycle after its character is accepted: the decode step sits between
// the group state and the result register, which doubles as the output stage.
// req.ready stays high while the result register is empty or being drained, so a
// stall on rsp holds one result and blocks req only until it is taken.
// Synchronous active-high reset clears group state and result valid.
`default_nettype none

module base64_stream_decoder_top (
   input  wire          clock,
   input  wire          reset,
   b64d_req_if.sink     req,
   b64d_rsp_if.source   rsp
);

   b64d_pkg::step_state_type state_ff;
   b64d_pkg::step_state_type state_in;
   b64d_pkg::req_word_type   req_word;
   b64d_pkg::rsp_word_type   rsp_ff;
   b64d_pkg::rsp_word_type   rsp_in;
   logic                     rsp_valid_ff;
   logic                     accept;

   assign req_word.char_code = req.char_code;
   assign req_word.last_char = req.last_char;

   // take a new character whenever the output slot frees up this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   b64d_step u_step (
      .cur_state (state_ff),
      .req_word  (req_word),
      .nxt_state (state_in),
      .rsp_word  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         if (req.ready) rsp_valid_ff <= req.valid;
      end
   end

   // payload holds while stalled; only loaded on accept
   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.byte_valid    = rsp_ff.byte_valid;
   assign rsp.data_byte     = rsp_ff.data_byte;
   assign rsp.bad_input     = rsp_ff.bad_input;
   assign rsp.end_of_string = rsp_ff.end_of_string;

endmodule

`default_nettype wire

FILE: rtl/core/b64d_checker.sv
// Port-level checks for the Base64 decoder top, attached by bind.
// Depends on base64_stream_decoder_top's interface ports.
`default_nettype none

module b64d_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_byte_valid,
   input wire [7:0] rsp_data_byte,
   input wire       rsp_bad_input,
   input wire       rsp_end_of_string
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_valid)
         && $stable(rsp_data_byte) && $stable(rsp_bad_input)
         && $stable(rsp_end_of_string))
      else $error("rsp word changed while stalled");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_data_byte == 8'h00)
      else $error("data_byte nonzero without byte_valid");

   a_no_byte_on_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_bad_input)
      else $error("byte emitted on bad string");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_byte_valid    (rsp.byte_valid),
   .rsp_data_byte     (rsp.data_byte),
   .rsp_bad_input     (rsp.bad_input),
   .rsp_end_of_string (rsp.end_of_string)
);

`default_nettype wire
